/* rtl/core/device_group_membership_table_top_defines.svh */
// Assertion macros for the group membership table.
`ifndef DEVICE_GROUP_MEMBERSHIP_TABLE_TOP_DEFINES_SVH
`define DEVICE_GROUP_MEMBERSHIP_TABLE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked on every edge outside reset.
`define DGMT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked on every edge, reset included.
`define DGMT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DGMT_ASSERT(lbl, clk, rst, prop, msg)
`define DGMT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/core/dgmt_pkg.sv */
`timescale 1ns / 1ps

package dgmt_pkg;

  localparam int ACTION_W = 3;
  localparam int DEVICE_W = 10;
  localparam int GROUP_W  = 8;
  localparam int STATUS_W = 2;

  localparam logic [ACTION_W-1:0] ACT_QUERY     = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CLR_DEV   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLR_GROUP = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_DEVICE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_GROUP  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY   = 2'd3;

  // Per-row lookup result handed from the row logic to the sequencer.
  typedef struct packed {
    logic hit;   // some slot holds the group
    logic full;  // no empty slot left
  } row_flags_t;

endpackage

/* rtl/core/dgmt_ram.sv */
`timescale 1ns / 1ps

module dgmt_ram #(
  parameter int DEPTH = 320,
  parameter int WIDTH = 32,
  parameter int AW    = 9
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/dgmt_row_logic.sv */
`timescale 1ns / 1ps

module dgmt_row_logic #(
  parameter int SLOTS = 4
) (
  input  logic [SLOTS*dgmt_pkg::GROUP_W-1:0]  row,
  input  logic [dgmt_pkg::GROUP_W-1:0]        group,
  input  logic [dgmt_pkg::ACTION_W-1:0]       action,
  output logic [SLOTS*dgmt_pkg::GROUP_W-1:0]  row_next,
  output dgmt_pkg::row_flags_t                flags
);
  import dgmt_pkg::*;

  logic [SLOTS-1:0] match;
  logic [SLOTS-1:0] empty;
  logic [SLOTS-1:0] first_empty;
  logic [SLOTS*GROUP_W-1:0] ins_row;
  logic [SLOTS*GROUP_W-1:0] rem_row;

  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      match[s]       = (row[s*GROUP_W +: GROUP_W] == group);
      empty[s]       = (row[s*GROUP_W +: GROUP_W] == '0);
      first_empty[s] = empty[s] && !seen;
      seen           = seen || empty[s];
    end
  end

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      ins_row[s*GROUP_W +: GROUP_W] = (first_empty[s] && !(|match)) ?
                                      group : row[s*GROUP_W +: GROUP_W];
      rem_row[s*GROUP_W +: GROUP_W] = match[s] ? '0 : row[s*GROUP_W +: GROUP_W];
    end
  end

  assign flags.hit  = |match;
  assign flags.full = !(|empty);

  always_comb begin
    unique case (action)
      ACT_INSERT:                row_next = ins_row;
      ACT_REMOVE, ACT_CLR_GROUP: row_next = rem_row;
      ACT_CLR_DEV:               row_next = '0;
      default:                   row_next = row;
    endcase
  end

endmodule

/* rtl/core/device_group_membership_table_top.sv */
`timescale 1ns / 1ps
// Channel   Handshake        Payload
// command   start / busy     action, device_index, group_number
// result    done (strobe)    is_member, status
//
// Query, insert, remove and clear-device: the row is read from the table RAM
// at the accepting edge, then modified and written back while done pulses.
// Clear-group streams every row through the same read port. After reset
// the RAM is swept to zero, one row a cycle, with busy high. Results are
// shown for one cycle only; the receiver cannot stall them.

`include "device_group_membership_table_top_defines.svh"

module device_group_membership_table_top #(
  parameter int DEVICE_COUNT     = 320,
  parameter int SLOTS_PER_DEVICE = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [dgmt_pkg::ACTION_W-1:0] action,
  input  logic [dgmt_pkg::DEVICE_W-1:0] device_index,
  input  logic [dgmt_pkg::GROUP_W-1:0]  group_number,
  output logic                          done,
  output logic                          is_member,
  output logic [dgmt_pkg::STATUS_W-1:0] status
);
  import dgmt_pkg::*;

  localparam int AW    = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
  localparam int ROW_W = SLOTS_PER_DEVICE * GROUP_W;
  localparam logic [AW-1:0] LAST_ROW = AW'(DEVICE_COUNT - 1);

  // Sequencer states
  localparam logic [1:0] S_INIT  = 2'd0;  // zero sweep after reset
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_ROW   = 2'd2;  // single-row read-modify-write
  localparam logic [1:0] S_SWEEP = 2'd3;  // clear-group walk

  logic [1:0]          state, state_next;
  logic [AW-1:0]       cnt, cnt_next;
  logic [ACTION_W-1:0] cmd_action;
  logic [GROUP_W-1:0]  cmd_group;
  logic [STATUS_W-1:0] cmd_status;
  logic                cmd_ok;  // checks passed and action is known

  // Front-end command checks
  logic                dev_bad, grp_bad, accept;
  logic [STATUS_W-1:0] chk_status;
  logic                chk_ok;

  // RAM ports
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata, row_next;
  row_flags_t       flags;
  logic             too_many;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign dev_bad = ({1'b0, device_index} >= (DEVICE_W + 1)'(DEVICE_COUNT));
  assign grp_bad = (group_number == '0);

  always_comb begin
    chk_status = ST_OK;
    chk_ok     = 1'b0;
    unique case (action)
      ACT_QUERY, ACT_INSERT, ACT_REMOVE: begin
        if (dev_bad) begin
          chk_status = ST_BAD_DEVICE;
        end else if (grp_bad) begin
          chk_status = ST_BAD_GROUP;
        end else begin
          chk_ok = 1'b1;
        end
      end
      ACT_CLR_DEV: begin
        if (dev_bad) begin
          chk_status = ST_BAD_DEVICE;
        end else begin
          chk_ok = 1'b1;
        end
      end
      ACT_CLR_GROUP: begin
        if (grp_bad) begin
          chk_status = ST_BAD_GROUP;
        end else begin
          chk_ok = 1'b1;
        end
      end
      default: ;  // unknown action: ok, no effect
    endcase
  end

  dgmt_row_logic #(
    .SLOTS(SLOTS_PER_DEVICE)
  ) u_row (
    .row     (ram_rdata),
    .group   (cmd_group),
    .action  (cmd_action),
    .row_next(row_next),
    .flags   (flags)
  );

  assign too_many = (cmd_action == ACT_INSERT) && !flags.hit && flags.full;

  dgmt_ram #(
    .DEPTH(DEVICE_COUNT),
    .WIDTH(ROW_W),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Reads and writes never hit the same row in one cycle: the sweep writes
  // row n while reading row n+1, and a new command only reads after the
  // previous write has landed.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ram_we     = 1'b0;
    ram_waddr  = cnt;
    ram_wdata  = row_next;
    ram_re     = 1'b0;
    ram_raddr  = device_index[AW-1:0];
    unique case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        cnt_next  = cnt + AW'(1);
        if (cnt == LAST_ROW) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ram_re = chk_ok;
          if (chk_ok && action == ACT_CLR_GROUP) begin
            ram_raddr  = '0;
            cnt_next   = '0;
            state_next = S_SWEEP;
          end else begin
            cnt_next   = chk_ok ? device_index[AW-1:0] : '0;
            state_next = S_ROW;
          end
        end
      end
      S_ROW: begin
        ram_we     = cmd_ok && !too_many && (cmd_action == ACT_INSERT ||
                     cmd_action == ACT_REMOVE || cmd_action == ACT_CLR_DEV);
        state_next = S_IDLE;
      end
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_raddr = cnt + AW'(1);
        if (cnt == LAST_ROW) begin
          state_next = S_IDLE;
        end else begin
          ram_re   = 1'b1;
          cnt_next = cnt + AW'(1);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Command latch (payload, no reset needed)
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_action <= action;
      cmd_group  <= group_number;
      cmd_status <= chk_status;
      cmd_ok     <= chk_ok;
    end
  end

  // Result strobe: end of a row transaction or last row of the sweep
  assign done = (state == S_ROW) || (state == S_SWEEP && cnt == LAST_ROW);
  assign is_member = (state == S_ROW) && cmd_ok &&
                     (cmd_action == ACT_QUERY) && flags.hit;
  assign status = (cmd_ok && too_many) ? ST_TOO_MANY : cmd_status;

  `DGMT_ASSERT(a_accept_busy, clk, rst, accept |=> busy, "accepted transaction did not raise busy")
  `DGMT_ASSERT(a_done_busy, clk, rst, done |-> busy, "result strobe while idle")
  `DGMT_ASSERT(a_too_many_insert, clk, rst, (done && status == ST_TOO_MANY) |-> (cmd_action == ACT_INSERT), "too-many status on a non-insert")
  `DGMT_ASSERT(a_member_query, clk, rst, is_member |-> (done && status == ST_OK && cmd_action == ACT_QUERY), "membership flag outside an ok query result")

endmodule

/* tb/dgmt_membership_checker.sv */
`timescale 1ns / 1ps

module dgmt_membership_checker #(
  parameter int DEVICE_COUNT     = 320,
  parameter int SLOTS_PER_DEVICE = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [dgmt_pkg::ACTION_W-1:0] action,
  input  logic [dgmt_pkg::DEVICE_W-1:0] device_index,
  input  logic [dgmt_pkg::GROUP_W-1:0]  group_number,
  input  logic                          done,
  input  logic                          is_member,
  input  logic [dgmt_pkg::STATUS_W-1:0] status,
  output int                            errors,
  output int                            pending
);
  import dgmt_pkg::*;

  typedef struct packed {
    logic                is_member;
    logic [STATUS_W-1:0] status;
  } answer_t;

  // Shadow copy of the membership table; 0 marks an empty slot.
  logic [GROUP_W-1:0] slots [DEVICE_COUNT][SLOTS_PER_DEVICE];
  answer_t            answer_q [$];
  int                 fail_count = 0;

  function automatic bit row_has(int dev, logic [GROUP_W-1:0] grp);
    for (int s = 0; s < SLOTS_PER_DEVICE; s++)
      if (slots[dev][s] == grp) return 1'b1;
    return 1'b0;
  endfunction

  // Applies one command to the shadow table and returns its answer.
  function automatic answer_t run_command(logic [ACTION_W-1:0] act,
                                          logic [DEVICE_W-1:0] dev,
                                          logic [GROUP_W-1:0]  grp);
    answer_t ans;
    bit      dev_ok;
    ans    = '0;
    dev_ok = (int'(dev) < DEVICE_COUNT);
    case (act)
      ACT_QUERY, ACT_INSERT, ACT_REMOVE: begin
        // device checked before group; errors leave the table alone
        if (!dev_ok) ans.status = ST_BAD_DEVICE;
        else if (grp == '0) ans.status = ST_BAD_GROUP;
        else if (act == ACT_QUERY) ans.is_member = row_has(int'(dev), grp);
        else if (act == ACT_INSERT) begin
          if (!row_has(int'(dev), grp)) begin
            ans.status = ST_TOO_MANY;
            for (int s = 0; s < SLOTS_PER_DEVICE; s++)
              if (ans.status == ST_TOO_MANY && slots[dev][s] == '0) begin
                slots[dev][s] = grp;
                ans.status    = ST_OK;
              end
          end
        end else begin
          for (int s = 0; s < SLOTS_PER_DEVICE; s++)
            if (slots[dev][s] == grp) slots[dev][s] = '0;
        end
      end
      ACT_CLR_DEV: begin
        if (!dev_ok) ans.status = ST_BAD_DEVICE;
        else for (int s = 0; s < SLOTS_PER_DEVICE; s++) slots[dev][s] = '0;
      end
      ACT_CLR_GROUP: begin
        if (grp == '0) ans.status = ST_BAD_GROUP;
        else begin
          for (int d = 0; d < DEVICE_COUNT; d++)
            for (int s = 0; s < SLOTS_PER_DEVICE; s++)
              if (slots[d][s] == grp) slots[d][s] = '0;
        end
      end
      default: ;  // unused codes: no effect, all-zero answer
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      for (int d = 0; d < DEVICE_COUNT; d++)
        for (int s = 0; s < SLOTS_PER_DEVICE; s++) slots[d][s] = '0;
      answer_q.delete();
    end else begin
      // result first: it belongs to an earlier command than one taken now
      if (done) begin
        if (answer_q.size() == 0) begin
          $error("unexpected result: is_member %0b status %0d", is_member, status);
          fail_count++;
        end else begin
          want = answer_q.pop_front();
          if (is_member !== want.is_member) begin
            $error("is_member: expected %0b, got %0b", want.is_member, is_member);
            fail_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        answer_q.push_back(run_command(action, device_index, group_number));
    end
    errors  <= fail_count;
    pending <= answer_q.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import dgmt_pkg::*;

  localparam int DEVICE_COUNT     = 320;
  localparam int SLOTS_PER_DEVICE = 4;
  localparam int RANDOM_ITEMS     = 1200;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                start        = 1'b0;
  logic [ACTION_W-1:0] action       = ACT_QUERY;
  logic [DEVICE_W-1:0] device_index = '0;
  logic [GROUP_W-1:0]  group_number = '0;
  logic                busy;
  logic                done;
  logic                is_member;
  logic [STATUS_W-1:0] status;
  int                  fail_count;
  int                  pending;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  device_group_membership_table_top #(
    .DEVICE_COUNT     (DEVICE_COUNT),
    .SLOTS_PER_DEVICE (SLOTS_PER_DEVICE)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .device_index (device_index),
    .group_number (group_number),
    .done         (done),
    .is_member    (is_member),
    .status       (status)
  );

  // Watches both channels, keeps the shadow table, compares every result.
  dgmt_membership_checker #(
    .DEVICE_COUNT     (DEVICE_COUNT),
    .SLOTS_PER_DEVICE (SLOTS_PER_DEVICE)
  ) membership_chk (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .device_index (device_index),
    .group_number (group_number),
    .done         (done),
    .is_member    (is_member),
    .status       (status),
    .errors       (fail_count),
    .pending      (pending)
  );

  // Presents one command and holds it until the transaction is taken
  // (start high, busy low at the edge). start is left high; the caller
  // lowers it only when a gap follows, so back-to-back commands never
  // see a low/high pair on start in the same step.
  task automatic send_command(logic [ACTION_W-1:0] act, logic [DEVICE_W-1:0] dev,
                              logic [GROUP_W-1:0] grp);
    start        <= 1'b1;
    action       <= act;
    device_index <= dev;
    group_number <= grp;
    do @(posedge clk); while (busy);
  endtask

  // Random sender gap with the given chance in percent.
  task automatic maybe_pause(int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Hold off until every outstanding command has been answered.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    logic [ACTION_W-1:0] act;
    logic [DEVICE_W-1:0] dev;
    logic [GROUP_W-1:0]  grp;
    int                  pick;
    int                  sent;
    int                  gap_pct [3];

    gap_pct = '{0, 54, 7};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // busy stays high during the post-reset RAM sweep; send_command waits it out

    // ---- directed ----
    send_command(ACT_QUERY,     10'd0,    8'd1);    // empty table
    send_command(ACT_INSERT,    10'd0,    8'd1);
    send_command(ACT_INSERT,    10'd0,    8'd1);    // already a member: ok, no change
    send_command(ACT_INSERT,    10'd0,    8'd255);
    send_command(ACT_INSERT,    10'd0,    8'd2);
    send_command(ACT_INSERT,    10'd0,    8'd3);    // row now full
    send_command(ACT_INSERT,    10'd0,    8'd4);    // too many groups
    send_command(ACT_QUERY,     10'd0,    8'd255);
    send_command(ACT_REMOVE,    10'd0,    8'd2);
    send_command(ACT_REMOVE,    10'd0,    8'd200);  // no match: still ok
    send_command(ACT_INSERT,    10'd0,    8'd4);    // reuses the freed slot
    send_command(ACT_INSERT,    10'(DEVICE_COUNT - 1), 8'd1);  // last device
    send_command(ACT_QUERY,     10'(DEVICE_COUNT),     8'd1);  // first bad device
    send_command(ACT_INSERT,    10'd1023, 8'd0);    // both bad: device wins
    send_command(ACT_REMOVE,    10'd5,    8'd0);    // bad group
    send_command(ACT_CLR_GROUP, 10'd1023, 8'd1);    // device index ignored
    send_command(ACT_QUERY,     10'(DEVICE_COUNT - 1), 8'd1);
    send_command(ACT_QUERY,     10'd0,    8'd255);  // other groups survive
    send_command(ACT_CLR_GROUP, 10'd0,    8'd0);    // bad group
    send_command(ACT_CLR_DEV,   10'd0,    8'd0);    // group ignored
    send_command(ACT_CLR_DEV,   10'd1023, 8'd7);    // bad device
    send_command(ACT_QUERY,     10'd0,    8'd4);
    send_command(3'd5,          10'd1,    8'd1);    // unused codes are ignored
    send_command(3'd6,          10'd1023, 8'd0);
    send_command(3'd7,          10'd2,    8'd255);
    drain_results();

    // ---- random, in three gap phases with a full drain between ----
    // Most traffic hits a handful of devices and groups so rows fill up,
    // overflow and get cleared; the rest spans the full field ranges.
    foreach (gap_pct[ph]) begin
      sent = 0;
      while (sent < RANDOM_ITEMS / 3) begin
        pick = $urandom_range(0, 99);
        if (pick < 30)      act = ACT_QUERY;
        else if (pick < 60) act = ACT_INSERT;
        else if (pick < 75) act = ACT_REMOVE;
        else if (pick < 83) act = ACT_CLR_DEV;
        else if (pick < 88) act = ACT_CLR_GROUP;   // slow: full table walk
        else if (pick < 93) act = 3'($urandom_range(5, 7));
        else                act = 3'($urandom_range(0, 7));

        pick = $urandom_range(0, 99);
        if (pick < 70)      dev = 10'($urandom_range(0, 7));
        else if (pick < 80) dev = 10'(DEVICE_COUNT - 1 - $urandom_range(0, 1));
        else if (pick < 92) dev = 10'($urandom_range(0, DEVICE_COUNT - 1));
        else                dev = 10'($urandom_range(DEVICE_COUNT, 1023));

        pick = $urandom_range(0, 99);
        if (pick < 80)      grp = 8'($urandom_range(1, 6));
        else if (pick < 85) grp = '0;
        else                grp = 8'($urandom_range(0, 255));

        send_command(act, dev, grp);
        if (act <= ACT_CLR_GROUP) sent++;
        maybe_pause(gap_pct[ph]);
      end
      drain_results();
    end

    // tail: room for a stray strobe after the last answer
    repeat (DEVICE_COUNT + 10) @(posedge clk);
    if (fail_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  // Watchdog, well above the slowest legal run (every command a table walk).
  initial begin
    #20_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
